/* hw/rtl/id_allocator_with_refcount_assert.svh */
// Assertion macros for the handle allocator.
// Included by the top level; no other dependencies.
`ifndef ID_ALLOCATOR_WITH_REFCOUNT_ASSERT_SVH
`define ID_ALLOCATOR_WITH_REFCOUNT_ASSERT_SVH
`ifndef ASSERT_OFF
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* hw/rtl/ida_pkg.sv */
// Shared types and codes for the handle allocator.
// No dependencies.
package ida_pkg;

	localparam int OPC_W = 3;
	localparam int ID_W  = 11;
	localparam int CNT_W = 16;
	localparam int STS_W = 3;

	localparam logic [OPC_W-1:0] OP_ALLOC   = 3'd0;
	localparam logic [OPC_W-1:0] OP_FREE    = 3'd1;
	localparam logic [OPC_W-1:0] OP_GRAB    = 3'd2;
	localparam logic [OPC_W-1:0] OP_RELEASE = 3'd3;
	localparam logic [OPC_W-1:0] OP_QUERY   = 3'd4;

	localparam logic [STS_W-1:0] STS_OK    = 3'd0;
	localparam logic [STS_W-1:0] STS_FULL  = 3'd1;
	localparam logic [STS_W-1:0] STS_RANGE = 3'd2;
	localparam logic [STS_W-1:0] STS_BUSY  = 3'd3;
	localparam logic [STS_W-1:0] STS_OVER  = 3'd4;
	localparam logic [STS_W-1:0] STS_UNDER = 3'd5;

	typedef struct packed {
		logic [OPC_W-1:0] opcode;
		logic [ID_W-1:0]  id;
	} req_t;

	typedef struct packed {
		logic [ID_W-1:0]  new_id;
		logic [CNT_W-1:0] count;
		logic [STS_W-1:0] status;
	} rsp_t;

	typedef struct packed {
		logic clr_en;
		logic rd_en;
		logic ex_en;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
	} sts_t;

endpackage

/* hw/rtl/ida_ctrl.sv */
// Sequencer for the handle allocator: clearing pass, accept, execute.
// Depends on ida_pkg.
module ida_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	input  ida_pkg::sts_t sts,
	output ida_pkg::cmd_t cmd
);

	localparam logic [1:0] S_CLR  = 2'd0;
	localparam logic [1:0] S_IDLE = 2'd1;
	localparam logic [1:0] S_EXEC = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       rsp_valid_q;
	logic       ex_go;

	assign req_ready  = (state_q == S_IDLE);
	assign ex_go      = (state_q == S_EXEC) && (!rsp_valid_q || rsp_ready);
	assign cmd.clr_en = (state_q == S_CLR);
	assign cmd.rd_en  = req_valid && req_ready;
	assign cmd.ex_en  = ex_go;
	assign rsp_valid  = rsp_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLR: begin
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (ex_go) state_d = S_IDLE;
			end
			default: state_d = S_CLR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ex_go) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

endmodule

/* hw/rtl/ida_dp.sv */
// Datapath of the handle allocator: table memory, list head, high water, result register.
// Depends on ida_pkg.
module ida_dp #(
	parameter int ENTRIES    = 1024,
	parameter int COUNT_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  ida_pkg::cmd_t cmd,
	output ida_pkg::sts_t sts,
	input  ida_pkg::req_t req,
	output ida_pkg::rsp_t rsp
);

	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int HW = $clog2(ENTRIES + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(ENTRIES - 1);

	logic [COUNT_BITS-1:0] mem [ENTRIES];

	logic [HW-1:0]         hw_q;
	logic [HW-1:0]         head_q;
	logic [AW-1:0]         clr_cnt_q;
	logic [ida_pkg::OPC_W-1:0] op_q;
	logic [ida_pkg::ID_W-1:0]  id_q;
	logic [AW-1:0]         idx_q;
	logic                  id_ok_q;
	logic                  head_ok_q;
	logic [COUNT_BITS-1:0] rdat_q;
	ida_pkg::rsp_t         rsp_q;

	logic                  head_ok;
	logic                  id_ok;
	logic [AW-1:0]         raddr;
	logic [HW-1:0]         hw_inc;
	logic [HW-1:0]         hw_d;
	logic [HW-1:0]         head_d;
	logic                  we;
	logic [AW-1:0]         waddr;
	logic [COUNT_BITS-1:0] wdata;
	logic [COUNT_BITS-1:0] cnt_val;
	ida_pkg::rsp_t         rsp_d;

	assign head_ok = (head_q != '0) && (32'(head_q) <= 32'(ENTRIES));
	assign id_ok   = (req.id != '0) && (32'(req.id) <= 32'(ENTRIES));
	assign raddr   = (req.opcode == ida_pkg::OP_ALLOC) ? AW'(head_q - 1'b1)
	                                                   : AW'(req.id - 1'b1);
	assign hw_inc  = hw_q + 1'b1;
	assign sts.clr_last = (clr_cnt_q == LAST_IDX);
	assign rsp     = rsp_q;

	always_comb begin
		hw_d    = hw_q;
		head_d  = head_q;
		we      = 1'b0;
		waddr   = idx_q;
		wdata   = '0;
		cnt_val = '0;
		rsp_d   = '0;
		case (op_q) inside
			ida_pkg::OP_ALLOC: begin
				if (head_ok_q) begin
					head_d = (32'(rdat_q) <= 32'(ENTRIES)) ? HW'(rdat_q) : '0;
					we     = 1'b1;
					rsp_d.new_id = ida_pkg::ID_W'(head_q);
				end else if (32'(hw_q) < 32'(ENTRIES)) begin
					head_d = '0;
					hw_d   = hw_inc;
					we     = 1'b1;
					waddr  = AW'(hw_q);
					rsp_d.new_id = ida_pkg::ID_W'(hw_inc);
				end else begin
					rsp_d.status = ida_pkg::STS_FULL;
				end
			end
			ida_pkg::OP_FREE, ida_pkg::OP_GRAB, ida_pkg::OP_RELEASE,
			ida_pkg::OP_QUERY: begin
				if (!id_ok_q) begin
					rsp_d.status = ida_pkg::STS_RANGE;
				end else if (op_q == ida_pkg::OP_FREE) begin
					if (rdat_q != '0) begin
						rsp_d.status = ida_pkg::STS_BUSY;
					end else begin
						we     = 1'b1;
						wdata  = COUNT_BITS'(head_q);
						head_d = HW'(id_q);
					end
				end else if (op_q == ida_pkg::OP_GRAB) begin
					if (&rdat_q) begin
						rsp_d.status = ida_pkg::STS_OVER;
					end else begin
						we      = 1'b1;
						wdata   = rdat_q + 1'b1;
						cnt_val = wdata;
					end
				end else if (op_q == ida_pkg::OP_RELEASE) begin
					if (rdat_q == '0) begin
						rsp_d.status = ida_pkg::STS_UNDER;
					end else begin
						we      = 1'b1;
						wdata   = rdat_q - 1'b1;
						cnt_val = wdata;
					end
				end else begin
					cnt_val = rdat_q;
				end
				rsp_d.count = ida_pkg::CNT_W'(cnt_val);
			end
			default: rsp_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_en) mem[clr_cnt_q] <= '0;
		else if (cmd.ex_en && we) mem[waddr] <= wdata;
		if (cmd.rd_en) rdat_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			op_q      <= req.opcode;
			id_q      <= req.id;
			idx_q     <= raddr;
			id_ok_q   <= id_ok;
			head_ok_q <= head_ok;
		end
		if (cmd.ex_en) rsp_q <= rsp_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_q      <= '0;
			head_q    <= '0;
			clr_cnt_q <= '0;
		end else begin
			if (cmd.clr_en) clr_cnt_q <= clr_cnt_q + 1'b1;
			if (cmd.ex_en) begin
				hw_q   <= hw_d;
				head_q <= head_d;
			end
		end
	end

endmodule

/* hw/rtl/id_allocator_with_refcount.sv */
// Top level of the handle allocator: sequencer plus datapath.
// Depends on ida_pkg, ida_ctrl, ida_dp and the assertion header.
//
// Hands out handle ids 1..ENTRIES from a LIFO free list linked through the
// table words, else from the never-used range, and keeps a saturating
// reference count per handle. Each request word yields exactly one response
// word. A request first has its table word read from the single-port-style
// memory; then the word, the list head and the response register are updated.
// The next request is taken once that update is done, and the update waits
// while a previous response is still unclaimed. After reset the table is
// cleared one word per cycle, so requests are refused until the clearing pass
// is done.
`include "id_allocator_with_refcount_assert.svh"
module id_allocator_with_refcount #(
	parameter int ENTRIES    = 1024,
	parameter int COUNT_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  ida_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output ida_pkg::rsp_t rsp
);

	ida_pkg::cmd_t cmd;
	ida_pkg::sts_t sts;

	ida_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ida_dp #(
		.ENTRIES    (ENTRIES),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.req    (req),
		.rsp    (rsp)
	);

	`ASSERT_SAME(a_no_req_in_clear, clk, arst_n, cmd.clr_en, !req_ready)
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req_valid && req_ready, !req_ready)
	`ASSERT_NEXT(a_rsp_after_exec, clk, arst_n, cmd.ex_en, rsp_valid)
	`ASSERT_SAME(a_exec_not_read, clk, arst_n, cmd.ex_en, !cmd.rd_en && !cmd.clr_en)

endmodule
